// File: hw/rtl/owhm_pkg.sv
// owhm_pkg: shared constants, codes, sine table and microcode rom for the
// omni-wheel h-bridge mixer. no dependencies.

package owhm_pkg;

  // command kinds
  localparam logic [2:0] KIND_HEADING = 3'd0;
  localparam logic [2:0] KIND_VECTOR  = 3'd1;
  localparam logic [2:0] KIND_RUN     = 3'd2;
  localparam logic [2:0] KIND_BRAKE   = 3'd3;
  localparam logic [2:0] KIND_STOP    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_ANGLE1 = 3'd0;
  localparam logic [2:0] CFG_ANGLE4 = 3'd3;
  localparam logic [2:0] CFG_BRAKE_ON_ZERO = 3'd4;

  // reset mounting angles
  localparam logic [8:0] ANGLE1_RST = 9'd45;
  localparam logic [8:0] ANGLE2_RST = 9'd135;
  localparam logic [8:0] ANGLE3_RST = 9'd225;
  localparam logic [8:0] ANGLE4_RST = 9'd315;

  // arithmetic constants
  localparam logic signed [18:0] SPEED_FULL = 19'sd25600;
  localparam logic signed [15:0] MIX_WEIGHT = 16'sd11585;  // 0.7071 in q2.14
  localparam logic signed [15:0] DIV25_RECIP = 16'sd5243; // 2^17 / 25, rounded up
  localparam logic signed [31:0] ROUND_HALF = 32'sd8192;
  localparam logic [10:0] DUTY_FULL = 11'd1024;
  localparam logic [12:0] ANGLE_BIAS = 13'd1170;          // 90 + 3 * 360

  // microcode step addresses
  localparam logic [2:0] PC_LOOKUP = 3'd0;
  localparam logic [2:0] PC_SUM    = 3'd2;
  localparam logic [2:0] PC_DONE   = 3'd5;
  localparam logic [2:0] PC_BRAKE  = 3'd6;
  localparam logic [2:0] PC_STOP   = 3'd7;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_MUL,
    OP_SUM,
    OP_WRITE,
    OP_DONE,
    OP_BRAKE,
    OP_STOP
  } op_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_LOOP
  } jmp_e;

  typedef struct packed {
    op_e        op;
    jmp_e       jmp;
    logic [2:0] target;
  } ctrl_word_t;

  // control program: per motor lookup, multiply, sum, multiply, write; then done, brake and stop steps
  function automatic ctrl_word_t ucode_rom(input logic [2:0] pc);
    ctrl_word_t cw;
    case (pc)
      3'd0:    cw = '{op: OP_LOOKUP, jmp: JMP_NONE,   target: PC_LOOKUP};
      3'd1:    cw = '{op: OP_MUL,    jmp: JMP_NONE,   target: PC_LOOKUP};
      3'd2:    cw = '{op: OP_SUM,    jmp: JMP_NONE,   target: PC_LOOKUP};
      3'd3:    cw = '{op: OP_MUL,    jmp: JMP_NONE,   target: PC_LOOKUP};
      3'd4:    cw = '{op: OP_WRITE,  jmp: JMP_LOOP,   target: PC_LOOKUP};
      3'd5:    cw = '{op: OP_DONE,   jmp: JMP_NONE,   target: PC_DONE};
      3'd6:    cw = '{op: OP_BRAKE,  jmp: JMP_ALWAYS, target: PC_DONE};
      3'd7:    cw = '{op: OP_STOP,   jmp: JMP_ALWAYS, target: PC_DONE};
      default: cw = '{op: OP_DONE,   jmp: JMP_NONE,   target: PC_DONE};
    endcase
    return cw;
  endfunction

  // round(16384 * sin(k deg)) for k = 0..90
  function automatic logic [15:0] quarter_sine(input logic [6:0] k);
    logic [15:0] v;
    case (k)
      7'd0:  v = 16'd0;     7'd1:  v = 16'd286;   7'd2:  v = 16'd572;
      7'd3:  v = 16'd857;   7'd4:  v = 16'd1143;  7'd5:  v = 16'd1428;
      7'd6:  v = 16'd1713;  7'd7:  v = 16'd1997;  7'd8:  v = 16'd2280;
      7'd9:  v = 16'd2563;  7'd10: v = 16'd2845;  7'd11: v = 16'd3126;
      7'd12: v = 16'd3406;  7'd13: v = 16'd3686;  7'd14: v = 16'd3964;
      7'd15: v = 16'd4240;  7'd16: v = 16'd4516;  7'd17: v = 16'd4790;
      7'd18: v = 16'd5063;  7'd19: v = 16'd5334;  7'd20: v = 16'd5604;
      7'd21: v = 16'd5872;  7'd22: v = 16'd6138;  7'd23: v = 16'd6402;
      7'd24: v = 16'd6664;  7'd25: v = 16'd6924;  7'd26: v = 16'd7182;
      7'd27: v = 16'd7438;  7'd28: v = 16'd7692;  7'd29: v = 16'd7943;
      7'd30: v = 16'd8192;  7'd31: v = 16'd8438;  7'd32: v = 16'd8682;
      7'd33: v = 16'd8923;  7'd34: v = 16'd9162;  7'd35: v = 16'd9397;
      7'd36: v = 16'd9630;  7'd37: v = 16'd9860;  7'd38: v = 16'd10087;
      7'd39: v = 16'd10311; 7'd40: v = 16'd10531; 7'd41: v = 16'd10749;
      7'd42: v = 16'd10963; 7'd43: v = 16'd11174; 7'd44: v = 16'd11381;
      7'd45: v = 16'd11585; 7'd46: v = 16'd11786; 7'd47: v = 16'd11982;
      7'd48: v = 16'd12176; 7'd49: v = 16'd12365; 7'd50: v = 16'd12551;
      7'd51: v = 16'd12733; 7'd52: v = 16'd12911; 7'd53: v = 16'd13085;
      7'd54: v = 16'd13255; 7'd55: v = 16'd13421; 7'd56: v = 16'd13583;
      7'd57: v = 16'd13741; 7'd58: v = 16'd13894; 7'd59: v = 16'd14044;
      7'd60: v = 16'd14189; 7'd61: v = 16'd14330; 7'd62: v = 16'd14466;
      7'd63: v = 16'd14598; 7'd64: v = 16'd14726; 7'd65: v = 16'd14849;
      7'd66: v = 16'd14968; 7'd67: v = 16'd15082; 7'd68: v = 16'd15191;
      7'd69: v = 16'd15296; 7'd70: v = 16'd15396; 7'd71: v = 16'd15491;
      7'd72: v = 16'd15582; 7'd73: v = 16'd15668; 7'd74: v = 16'd15749;
      7'd75: v = 16'd15826; 7'd76: v = 16'd15897; 7'd77: v = 16'd15964;
      7'd78: v = 16'd16026; 7'd79: v = 16'd16083; 7'd80: v = 16'd16135;
      7'd81: v = 16'd16182; 7'd82: v = 16'd16225; 7'd83: v = 16'd16262;
      7'd84: v = 16'd16294; 7'd85: v = 16'd16322; 7'd86: v = 16'd16344;
      7'd87: v = 16'd16362; 7'd88: v = 16'd16374; 7'd89: v = 16'd16382;
      7'd90: v = 16'd16384;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // q2.14 sine of an angle in 0..359 degrees, quadrant folded
  function automatic logic signed [15:0] sine_q14(input logic [8:0] a);
    logic [8:0]  k;
    logic        neg;
    logic [15:0] mag;
    if (a <= 9'd90) begin
      k = a;
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      k = 9'd180 - a;
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      k = a - 9'd180;
      neg = 1'b1;
    end else begin
      k = 9'd360 - a;
      neg = 1'b1;
    end
    mag = quarter_sine(k[6:0]);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// File: hw/rtl/omni_wheel_hbridge_mixer.sv
// omni_wheel_hbridge_mixer: microcoded mixer that turns drive commands into
// phase and enable duties for four h-bridges. depends on owhm_pkg.
//
//   channel | signals                                   | flow
//   --------+-------------------------------------------+---------
//   in      | in_valid_i / in_stall_o, command fields   | to block
//   out     | out_valid_o / out_stall_i, duties + awake | from block
//   cfg     | cfg_valid_i / cfg_ready_o, index + data   | to block
//
// heading and vector drive run five microcode steps per motor through the one
// shared multiplier, then done posts the result; run-one runs sum, multiply,
// write, done; brake-one and stop-all their own step, done; others only done.
// in_stall_o is high while running; a held result does not block the next
// transfer, only its done step. reset restores the angles, clears held duties.

module omni_wheel_hbridge_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [10:0] heading_deg_i,
  input  logic signed [15:0] magnitude_i,
  input  logic signed [15:0] rotation_offset_i,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic [2:0]         motor_select_i,
  input  logic signed [15:0] single_speed_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [10:0]        phase_duty_m1_o,
  output logic [10:0]        enable_duty_m1_o,
  output logic [10:0]        phase_duty_m2_o,
  output logic [10:0]        enable_duty_m2_o,
  output logic [10:0]        phase_duty_m3_o,
  output logic [10:0]        enable_duty_m3_o,
  output logic [10:0]        phase_duty_m4_o,
  output logic [10:0]        enable_duty_m4_o,
  output logic               driver_awake_o,
  // configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i
);

  // control state
  logic       run_q, run_d;
  logic [2:0] pc_q, pc_d;
  logic [1:0] motor_q, motor_d;
  logic       out_valid_q, out_valid_d;

  // configuration and held duties
  logic [8:0]  angle_q [4];
  logic        brake_zero_q;
  logic [10:0] phase_q [4];
  logic [10:0] enable_q [4];
  logic [10:0] phase_d [4];
  logic [10:0] enable_d [4];
  logic        awake_q, awake_d;

  // command and datapath registers
  logic [2:0]         kind_q;
  logic signed [10:0] head_q;
  logic signed [15:0] mag_q, rot_q, vx_q, vy_q, single_q;
  logic signed [15:0] opa_q, opa_d;
  logic signed [17:0] opb_q, opb_d;
  logic signed [31:0] prod_q, prod_d;
  logic               neg_q, neg_d, zero_q, zero_d;

  // result registers
  logic [10:0] out_phase_q [4];
  logic [10:0] out_enable_q [4];
  logic        out_awake_q;

  owhm_pkg::ctrl_word_t cw;
  logic in_xfer, emit, loop_more;

  assign cw        = owhm_pkg::ucode_rom(pc_q);
  assign in_stall_o  = run_q;
  assign in_xfer   = in_valid_i && !run_q;
  assign cfg_ready_o = 1'b1;
  assign emit      = run_q && (cw.op == owhm_pkg::OP_DONE) && !(out_valid_q && out_stall_i);
  assign loop_more = ((kind_q == owhm_pkg::KIND_HEADING) || (kind_q == owhm_pkg::KIND_VECTOR))
                     && (motor_q != 2'd3);

  // angle reduction: 90 - heading + angle, brought into 0..359
  logic [12:0] ang_t0;
  logic [12:0] ang_t1, ang_t2, ang_t3;
  logic [8:0]  ang_red;
  always_comb begin
    ang_t0 = 13'(angle_q[motor_q]) + owhm_pkg::ANGLE_BIAS
             - 13'($signed({{2{head_q[10]}}, head_q}));
    ang_t1 = (ang_t0 >= 13'd1440) ? ang_t0 - 13'd1440 : ang_t0;
    ang_t2 = (ang_t1 >= 13'd720)  ? ang_t1 - 13'd720  : ang_t1;
    ang_t3 = (ang_t2 >= 13'd360)  ? ang_t2 - 13'd360  : ang_t2;
    ang_red = ang_t3[8:0];
  end

  // vector mix of x and y for the current motor
  logic signed [17:0] vx_e, vy_e, mix;
  always_comb begin
    vx_e = {{2{vx_q[15]}}, vx_q};
    vy_e = {{2{vy_q[15]}}, vy_q};
    case (motor_q)
      2'd0:    mix = -vx_e - vy_e;
      2'd1:    mix = vx_e - vy_e;
      2'd2:    mix = vx_e + vy_e;
      default: mix = vy_e - vx_e;
    endcase
  end

  // rescale and add rotation, or take the run-one speed as is, then saturate
  logic signed [31:0] rnd;
  logic signed [18:0] raw, spd;
  logic [15:0]        spd_abs;
  always_comb begin
    rnd = prod_q + owhm_pkg::ROUND_HALF;
    if (kind_q == owhm_pkg::KIND_RUN) begin
      raw = {{3{single_q[15]}}, single_q};
    end else begin
      raw = $signed({rnd[31], rnd[31:14]}) + $signed({{3{rot_q[15]}}, rot_q});
    end
    if (raw > owhm_pkg::SPEED_FULL) begin
      spd = owhm_pkg::SPEED_FULL;
    end else if (raw < -owhm_pkg::SPEED_FULL) begin
      spd = -owhm_pkg::SPEED_FULL;
    end else begin
      spd = raw;
    end
    spd_abs = spd[18] ? 16'(-spd) : spd[15:0];
  end

  // shared multiplier
  logic signed [33:0] mul_full;
  assign mul_full = opa_q * opb_q;

  // datapath and held state updates
  logic [10:0] duty;
  assign duty = prod_q[27:17];
  always_comb begin
    opa_d   = opa_q;
    opb_d   = opb_q;
    prod_d  = prod_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    awake_d = awake_q;
    for (int i = 0; i < 4; i++) begin
      phase_d[i]  = phase_q[i];
      enable_d[i] = enable_q[i];
    end
    if (run_q) begin
      case (cw.op)
        owhm_pkg::OP_LOOKUP: begin
          if (kind_q == owhm_pkg::KIND_HEADING) begin
            opa_d = owhm_pkg::sine_q14(ang_red);
            opb_d = {{2{mag_q[15]}}, mag_q};
          end else begin
            opa_d = owhm_pkg::MIX_WEIGHT;
            opb_d = mix;
          end
        end
        owhm_pkg::OP_MUL: begin
          prod_d = mul_full[31:0];
        end
        owhm_pkg::OP_SUM: begin
          neg_d  = spd[18];
          zero_d = (spd == 19'sd0);
          opa_d  = owhm_pkg::DIV25_RECIP;
          opb_d  = $signed({2'b00, spd_abs}) + 18'sd12;
        end
        owhm_pkg::OP_WRITE: begin
          awake_d = 1'b1;
          if (zero_q) begin
            phase_d[motor_q]  = brake_zero_q ? owhm_pkg::DUTY_FULL : 11'd0;
            enable_d[motor_q] = brake_zero_q ? owhm_pkg::DUTY_FULL : 11'd0;
          end else if (neg_q) begin
            phase_d[motor_q]  = duty;
            enable_d[motor_q] = 11'd0;
          end else begin
            phase_d[motor_q]  = 11'd0;
            enable_d[motor_q] = duty;
          end
        end
        owhm_pkg::OP_BRAKE: begin
          phase_d[motor_q]  = owhm_pkg::DUTY_FULL;
          enable_d[motor_q] = owhm_pkg::DUTY_FULL;
        end
        owhm_pkg::OP_STOP: begin
          awake_d = 1'b0;
          for (int i = 0; i < 4; i++) begin
            phase_d[i]  = 11'd0;
            enable_d[i] = 11'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer: dispatch on transfer, then step the program
  logic sel_ok;
  assign sel_ok = (motor_select_i >= 3'd1) && (motor_select_i <= 3'd4);
  always_comb begin
    run_d       = run_q;
    pc_d        = pc_q;
    motor_d     = motor_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_xfer) begin
      run_d   = 1'b1;
      motor_d = 2'(motor_select_i - 3'd1);
      case (kind_i)
        owhm_pkg::KIND_HEADING, owhm_pkg::KIND_VECTOR: begin
          pc_d    = owhm_pkg::PC_LOOKUP;
          motor_d = 2'd0;
        end
        owhm_pkg::KIND_RUN:   pc_d = sel_ok ? owhm_pkg::PC_SUM : owhm_pkg::PC_DONE;
        owhm_pkg::KIND_BRAKE: pc_d = sel_ok ? owhm_pkg::PC_BRAKE : owhm_pkg::PC_DONE;
        owhm_pkg::KIND_STOP:  pc_d = owhm_pkg::PC_STOP;
        default:              pc_d = owhm_pkg::PC_DONE;
      endcase
    end else if (run_q) begin
      if (cw.op == owhm_pkg::OP_DONE) begin
        if (emit) begin
          run_d       = 1'b0;
          out_valid_d = 1'b1;
        end
      end else begin
        case (cw.jmp)
          owhm_pkg::JMP_ALWAYS: pc_d = cw.target;
          owhm_pkg::JMP_LOOP: begin
            if (loop_more) begin
              pc_d    = cw.target;
              motor_d = motor_q + 2'd1;
            end else begin
              pc_d = pc_q + 3'd1;
            end
          end
          default: pc_d = pc_q + 3'd1;
        endcase
      end
    end
  end

  // control, configuration and held state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= 1'b0;
      pc_q         <= owhm_pkg::PC_DONE;
      motor_q      <= 2'd0;
      out_valid_q  <= 1'b0;
      angle_q[0]   <= owhm_pkg::ANGLE1_RST;
      angle_q[1]   <= owhm_pkg::ANGLE2_RST;
      angle_q[2]   <= owhm_pkg::ANGLE3_RST;
      angle_q[3]   <= owhm_pkg::ANGLE4_RST;
      brake_zero_q <= 1'b0;
      awake_q      <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        phase_q[i]  <= 11'd0;
        enable_q[i] <= 11'd0;
      end
    end else begin
      run_q       <= run_d;
      pc_q        <= pc_d;
      motor_q     <= motor_d;
      out_valid_q <= out_valid_d;
      awake_q     <= awake_d;
      for (int i = 0; i < 4; i++) begin
        phase_q[i]  <= phase_d[i];
        enable_q[i] <= enable_d[i];
      end
      // configuration transfer
      if (cfg_valid_i) begin
        if (cfg_index_i <= owhm_pkg::CFG_ANGLE4) begin
          angle_q[cfg_index_i[1:0] - owhm_pkg::CFG_ANGLE1[1:0]] <= cfg_data_i;
        end else if (cfg_index_i == owhm_pkg::CFG_BRAKE_ON_ZERO) begin
          brake_zero_q <= cfg_data_i[0];
        end
      end
    end
  end

  // payload, datapath and result registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q   <= kind_i;
      head_q   <= heading_deg_i;
      mag_q    <= magnitude_i;
      rot_q    <= rotation_offset_i;
      vx_q     <= vec_x_i;
      vy_q     <= vec_y_i;
      single_q <= single_speed_i;
    end
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    if (emit) begin
      for (int i = 0; i < 4; i++) begin
        out_phase_q[i]  <= phase_q[i];
        out_enable_q[i] <= enable_q[i];
      end
      out_awake_q <= awake_q;
    end
  end

  // result ports
  assign out_valid_o      = out_valid_q;
  assign phase_duty_m1_o  = out_phase_q[0];
  assign enable_duty_m1_o = out_enable_q[0];
  assign phase_duty_m2_o  = out_phase_q[1];
  assign enable_duty_m2_o = out_enable_q[1];
  assign phase_duty_m3_o  = out_phase_q[2];
  assign enable_duty_m3_o = out_enable_q[2];
  assign phase_duty_m4_o  = out_phase_q[3];
  assign enable_duty_m4_o = out_enable_q[3];
  assign driver_awake_o   = out_awake_q;

  // a command transfer starts the sequencer
  a_xfer_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> run_q)
    else $error("sequencer did not start after command transfer");

  // the last motor write leaves the loop for the done step
  a_loop_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && (cw.op == owhm_pkg::OP_WRITE) && (motor_q == 2'd3) |=>
    (pc_q == owhm_pkg::PC_DONE))
    else $error("motor loop ran past the last motor");

  // stop-all puts the driver to sleep
  a_stop_sleeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && (cw.op == owhm_pkg::OP_STOP) |=> !awake_q)
    else $error("driver still awake after stop");

  // held duties never exceed full scale
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q[0] <= owhm_pkg::DUTY_FULL) && (enable_q[0] <= owhm_pkg::DUTY_FULL) &&
    (phase_q[1] <= owhm_pkg::DUTY_FULL) && (enable_q[1] <= owhm_pkg::DUTY_FULL) &&
    (phase_q[2] <= owhm_pkg::DUTY_FULL) && (enable_q[2] <= owhm_pkg::DUTY_FULL) &&
    (phase_q[3] <= owhm_pkg::DUTY_FULL) && (enable_q[3] <= owhm_pkg::DUTY_FULL))
    else $error("duty above full scale");

endmodule
